FILE: src/cpu65_pkg.sv
// Package for the 65C02 subset core: channel item types, opcodes, flag bits.
// No dependencies; used by every module of the core.
`timescale 1ns / 1ps
package cpu65_pkg;

  // One input item: start command or returned read byte
  typedef struct packed {
    logic       req_type;
    logic [7:0] read_data;
  } item_t;

  // One bus request
  typedef struct packed {
    logic [15:0] bus_addr;
    logic        is_write;
    logic [7:0]  write_data;
    logic        fault;
    logic        last;
  } res_t;

  localparam logic        REQ_START     = 1'b0;
  localparam logic [15:0] VEC_LO_ADDR   = 16'h7FFC;
  localparam logic [15:0] VEC_HI_ADDR   = 16'h7FFD;
  localparam logic [15:0] STACK_BASE_RST = 16'h0100;

  // Flag bit positions
  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_V = 4;
  localparam int FL_N = 5;

  // Opcodes
  localparam logic [7:0] OP_PHP = 8'h08, OP_ORA_I = 8'h09, OP_ORA_A = 8'h0D;
  localparam logic [7:0] OP_JSR = 8'h20, OP_PLP = 8'h28, OP_AND_I = 8'h29;
  localparam logic [7:0] OP_PHA = 8'h48, OP_JMP = 8'h4C, OP_CLI = 8'h58;
  localparam logic [7:0] OP_RTS = 8'h60, OP_STZ_Z = 8'h64, OP_RMB6 = 8'h67;
  localparam logic [7:0] OP_PLA = 8'h68, OP_SEI = 8'h78, OP_BRA = 8'h80;
  localparam logic [7:0] OP_STA_Z = 8'h85, OP_SMB0 = 8'h87, OP_DEY = 8'h88;
  localparam logic [7:0] OP_STA_A = 8'h8D, OP_STX_A = 8'h8E, OP_BCC = 8'h90;
  localparam logic [7:0] OP_STA_ZI = 8'h92, OP_STA_ZX = 8'h95, OP_TYA = 8'h98;
  localparam logic [7:0] OP_TXS = 8'h9A, OP_STZ_A = 8'h9C, OP_STA_AX = 8'h9D;
  localparam logic [7:0] OP_LDY_I = 8'hA0, OP_LDX_I = 8'hA2, OP_LDA_Z = 8'hA5;
  localparam logic [7:0] OP_SMB2 = 8'hA7, OP_LDA_I = 8'hA9, OP_LDA_A = 8'hAD;
  localparam logic [7:0] OP_LDA_AX = 8'hBD, OP_DEC_Z = 8'hC6, OP_CMP_I = 8'hC9;
  localparam logic [7:0] OP_DEX = 8'hCA, OP_WAI = 8'hCB, OP_BNE = 8'hD0;
  localparam logic [7:0] OP_CPX_I = 8'hE0, OP_INC_Z = 8'hE6, OP_SMB6 = 8'hE7;
  localparam logic [7:0] OP_INX = 8'hE8, OP_NOP = 8'hEA, OP_BEQ = 8'hF0;
  localparam logic [7:0] OP_SMB7 = 8'hF7;

  // Instruction length class
  localparam logic [1:0] LEN_BAD = 2'd0;
  localparam logic [1:0] LEN_ONE = 2'd1;
  localparam logic [1:0] LEN_TWO = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  function automatic logic [1:0] op_len(input logic [7:0] op);
    logic [1:0] len;
    len = LEN_BAD;
    case (op)
      OP_PHP, OP_PLP, OP_PHA, OP_CLI, OP_RTS, OP_PLA, OP_SEI, OP_DEY,
      OP_TYA, OP_TXS, OP_DEX, OP_WAI, OP_INX, OP_NOP: len = LEN_ONE;
      OP_ORA_I, OP_AND_I, OP_LDY_I, OP_LDX_I, OP_LDA_I, OP_CMP_I, OP_CPX_I,
      OP_BRA, OP_BCC, OP_BNE, OP_BEQ, OP_STZ_Z, OP_STA_Z, OP_STA_ZX,
      OP_LDA_Z, OP_RMB6, OP_SMB0, OP_SMB2, OP_DEC_Z, OP_INC_Z, OP_SMB6,
      OP_SMB7, OP_STA_ZI: len = LEN_TWO;
      OP_ORA_A, OP_JSR, OP_JMP, OP_STA_A, OP_STX_A, OP_STZ_A, OP_STA_AX,
      OP_LDA_A, OP_LDA_AX: len = LEN_THREE;
      default: len = LEN_BAD;
    endcase
    return len;
  endfunction

  function automatic res_t mk_req(input logic [15:0] addr, input logic wr,
                                  input logic [7:0] data, input logic flt);
    res_t r;
    r.bus_addr   = addr;
    r.is_write   = wr;
    r.write_data = data;
    r.fault      = flt;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

FILE: src/cpu65_front.sv
// Front end of the 65C02 subset core: two-entry queue of input items.
// Depends on cpu65_pkg.
`timescale 1ns / 1ps
module cpu65_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  cpu65_pkg::item_t in_item,
  output logic            q_valid,
  output cpu65_pkg::item_t q_item,
  input  logic            q_pop
);
  import cpu65_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  // Handshake
  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem_r[rd_ptr_r];

  // Pointer and fill update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

FILE: src/cpu65_back.sv
// Back end of the 65C02 subset core: register file, sequencer and request buffer.
// Depends on cpu65_pkg.
`timescale 1ns / 1ps
module cpu65_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic             q_valid,
  input  cpu65_pkg::item_t q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output cpu65_pkg::res_t  out_res
);
  import cpu65_pkg::*;

  localparam logic [3:0] PH_IDLE = 4'd0, PH_VLO = 4'd1, PH_VHI = 4'd2;
  localparam logic [3:0] PH_FETCH = 4'd3, PH_OP1 = 4'd4, PH_OP2 = 4'd5;
  localparam logic [3:0] PH_DATA = 4'd6, PH_IND1 = 4'd7, PH_IND2 = 4'd8;
  localparam logic [3:0] PH_POP1 = 4'd9, PH_POP2 = 4'd10;

  logic [15:0] base_r;
  logic [7:0]  a_r, a_nxt, x_r, x_nxt, y_r, y_nxt, s_r, s_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [5:0]  fl_r, fl_nxt;
  logic [3:0]  ph_r, ph_nxt;
  logic [7:0]  opl_r, opl_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  res_t        res_r [3];
  res_t        rs [3];
  logic [1:0]  n;
  logic [1:0]  cnt_r;
  logic [1:0]  idx_r;
  logic        out_xfer;
  logic        load;
  logic [7:0]  d;
  logic [15:0] ad;
  logic [7:0]  v;
  logic        take;

  // Request buffer handshake
  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = res_r[idx_r];
  assign out_xfer  = out_valid && !out_stall;
  assign q_pop     = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_xfer);
  assign load      = q_pop && q_valid;
  assign d         = q_item.read_data;

  // Execute one item: next state and up to three requests
  always_comb begin
    a_nxt = a_r; x_nxt = x_r; y_nxt = y_r; s_nxt = s_r; pc_nxt = pc_r;
    fl_nxt = fl_r; ph_nxt = ph_r; opl_nxt = opl_r; lo_nxt = lo_r; hi_nxt = hi_r;
    n = 2'd0;
    ad = 16'd0;
    v = 8'd0;
    take = 1'b0;
    for (int i = 0; i < 3; i++) rs[i] = mk_req(16'd0, 1'b0, 8'd0, 1'b0);

    if (q_item.req_type == REQ_START) begin
      fl_nxt[FL_I] = 1'b1;
      fl_nxt[FL_D] = 1'b0;
      rs[n] = mk_req(VEC_LO_ADDR, 1'b0, 8'd0, 1'b0); n = n + 2'd1;
      ph_nxt = PH_VLO;
    end else begin
      unique case (ph_r)
        PH_VLO: begin
          lo_nxt = d;
          rs[n] = mk_req(VEC_HI_ADDR, 1'b0, 8'd0, 1'b0); n = n + 2'd1;
          ph_nxt = PH_VHI;
        end
        PH_VHI: begin
          hi_nxt = d;
          pc_nxt = {d, lo_r};
          rs[n] = mk_req(pc_nxt, 1'b0, 8'd0, 1'b0); n = n + 2'd1;
          ph_nxt = PH_FETCH;
        end
        PH_FETCH: begin
          opl_nxt = d;
          unique case (op_len(d))
            LEN_BAD: begin
              rs[n] = mk_req(pc_r, 1'b0, 8'd0, 1'b1); n = n + 2'd1;
            end
            LEN_ONE: begin
              // Implied instructions
              ph_nxt = PH_FETCH;
              case (d)
                OP_PHP: begin
                  rs[n] = mk_req(base_r + {8'd0, s_r}, 1'b1,
                                 {fl_r[FL_N], fl_r[FL_V], 2'b11, fl_r[3:0]}, 1'b0);
                  n = n + 2'd1;
                  s_nxt = s_r + 8'd1;
                end
                OP_PHA: begin
                  rs[n] = mk_req(base_r + {8'd0, s_r}, 1'b1, a_r, 1'b0);
                  n = n + 2'd1;
                  s_nxt = s_r + 8'd1;
                end
                OP_CLI: fl_nxt[FL_I] = 1'b0;
                OP_SEI: fl_nxt[FL_I] = 1'b1;
                OP_DEY: begin
                  y_nxt = y_r - 8'd1;
                  fl_nxt[FL_Z] = (y_nxt == 8'd0); fl_nxt[FL_N] = y_nxt[7];
                end
                OP_TYA: begin
                  a_nxt = y_r;
                  fl_nxt[FL_Z] = (y_r == 8'd0); fl_nxt[FL_N] = y_r[7];
                end
                OP_TXS: s_nxt = x_r;
                OP_DEX: begin
                  x_nxt = x_r - 8'd1;
                  fl_nxt[FL_Z] = (x_nxt == 8'd0); fl_nxt[FL_N] = x_nxt[7];
                end
                OP_INX: begin
                  x_nxt = x_r + 8'd1;
                  fl_nxt[FL_Z] = (x_nxt == 8'd0); fl_nxt[FL_N] = x_nxt[7];
                end
                default: ;
              endcase
              if (d == OP_PLP || d == OP_PLA || d == OP_RTS) begin
                // Pull: pre-decrement then read
                s_nxt = s_r - 8'd1;
                rs[n] = mk_req(base_r + {8'd0, s_nxt}, 1'b0, 8'd0, 1'b0); n = n + 2'd1;
                ph_nxt = PH_POP1;
              end else begin
                pc_nxt = pc_r + 16'd1;
                rs[n] = mk_req(pc_nxt, 1'b0, 8'd0, 1'b0); n = n + 2'd1;
              end
            end
            default: begin
              rs[n] = mk_req(pc_r + 16'd1, 1'b0, 8'd0, 1'b0); n = n + 2'd1;
              ph_nxt = PH_OP1;
            end
          endcase
        end
        PH_OP1: begin
          lo_nxt = d;
          ph_nxt = PH_FETCH;
          pc_nxt = pc_r + 16'd2;
          case (opl_r)
            OP_ORA_I: begin
              a_nxt = a_r | d;
              fl_nxt[FL_Z] = (a_nxt == 8'd0); fl_nxt[FL_N] = a_nxt[7];
            end
            OP_AND_I: begin
              a_nxt = a_r & d;
              fl_nxt[FL_Z] = (a_nxt == 8'd0); fl_nxt[FL_N] = a_nxt[7];
            end
            OP_LDY_I: begin
              y_nxt = d; fl_nxt[FL_Z] = (d == 8'd0); fl_nxt[FL_N] = d[7];
            end
            OP_LDX_I: begin
              x_nxt = d; fl_nxt[FL_Z] = (d == 8'd0); fl_nxt[FL_N] = d[7];
            end
            OP_LDA_I: begin
              a_nxt = d; fl_nxt[FL_Z] = (d == 8'd0); fl_nxt[FL_N] = d[7];
            end
            OP_CMP_I: begin
              v = a_r - d;
              fl_nxt[FL_C] = (a_r >= d); fl_nxt[FL_Z] = (a_r == d); fl_nxt[FL_N] = v[7];
            end
            OP_CPX_I: begin
              v = x_r - d;
              fl_nxt[FL_C] = (x_r >= d); fl_nxt[FL_Z] = (x_r == d); fl_nxt[FL_N] = v[7];
            end
            OP_BRA, OP_BCC, OP_BNE, OP_BEQ: begin
              take = (opl_r == OP_BRA) || (opl_r == OP_BCC && !fl_r[FL_C]) ||
                     (opl_r == OP_BNE && !fl_r[FL_Z]) || (opl_r == OP_BEQ && fl_r[FL_Z]);
              if (take) pc_nxt = pc_r + 16'd2 + {{8{d[7]}}, d};
            end
            OP_STZ_Z: begin
              rs[n] = mk_req({8'd0, d}, 1'b1, 8'd0, 1'b0); n = n + 2'd1;
            end
            OP_STA_Z: begin
              rs[n] = mk_req({8'd0, d}, 1'b1, a_r, 1'b0); n = n + 2'd1;
            end
            OP_STA_ZX: begin
              rs[n] = mk_req({8'd0, d + x_r}, 1'b1, a_r, 1'b0); n = n + 2'd1;
            end
            OP_STA_ZI: begin
              pc_nxt = pc_r;
              ph_nxt = PH_IND1;
            end
            OP_LDA_Z, OP_RMB6, OP_SMB0, OP_SMB2, OP_DEC_Z, OP_INC_Z, OP_SMB6,
            OP_SMB7: begin
              pc_nxt = pc_r;
              ph_nxt = PH_DATA;
            end
            default: begin
              // Absolute: fetch high operand byte
              pc_nxt = pc_r;
              ph_nxt = PH_OP2;
            end
          endcase
          if (ph_nxt == PH_FETCH) begin
            rs[n] = mk_req(pc_nxt, 1'b0, 8'd0, 1'b0); n = n + 2'd1;
          end else if (ph_nxt == PH_OP2) begin
            rs[n] = mk_req(pc_r + 16'd2, 1'b0, 8'd0, 1'b0); n = n + 2'd1;
          end else begin
            rs[n] = mk_req({8'd0, d}, 1'b0, 8'd0, 1'b0); n = n + 2'd1;
          end
        end
        PH_OP2: begin
          hi_nxt = d;
          ad = {d, lo_r};
          ph_nxt = PH_FETCH;
          pc_nxt = pc_r + 16'd3;
          case (opl_r)
            OP_JSR: begin
              v = 8'(pc_r + 16'd2);
              rs[0] = mk_req(base_r + {8'd0, s_r}, 1'b1, v, 1'b0);
              s_nxt = s_r + 8'd1;
              ad = pc_r + 16'd2;
              rs[1] = mk_req(base_r + {8'd0, s_nxt}, 1'b1, ad[15:8], 1'b0);
              s_nxt = s_r + 8'd2;
              n = 2'd2;
              pc_nxt = {d, lo_r};
            end
            OP_JMP: pc_nxt = ad;
            OP_STA_A: begin
              rs[n] = mk_req(ad, 1'b1, a_r, 1'b0); n = n + 2'd1;
            end
            OP_STX_A: begin
              rs[n] = mk_req(ad, 1'b1, x_r, 1'b0); n = n + 2'd1;
            end
            OP_STZ_A: begin
              rs[n] = mk_req(ad, 1'b1, 8'd0, 1'b0); n = n + 2'd1;
            end
            OP_STA_AX: begin
              rs[n] = mk_req(ad + {8'd0, x_r}, 1'b1, a_r, 1'b0); n = n + 2'd1;
            end
            OP_LDA_AX: begin
              pc_nxt = pc_r;
              ph_nxt = PH_DATA;
              ad = ad + {8'd0, x_r};
            end
            default: begin
              pc_nxt = pc_r;
              ph_nxt = PH_DATA;
            end
          endcase
          if (ph_nxt == PH_FETCH) begin
            rs[n] = mk_req(pc_nxt, 1'b0, 8'd0, 1'b0); n = n + 2'd1;
          end else begin
            rs[n] = mk_req(ad, 1'b0, 8'd0, 1'b0); n = n + 2'd1;
          end
        end
        PH_DATA: begin
          ph_nxt = PH_FETCH;
          pc_nxt = pc_r + 16'd2;
          case (opl_r)
            OP_LDA_Z: begin
              a_nxt = d; fl_nxt[FL_Z] = (d == 8'd0); fl_nxt[FL_N] = d[7];
            end
            OP_ORA_A: begin
              a_nxt = a_r | d; pc_nxt = pc_r + 16'd3;
              fl_nxt[FL_Z] = (a_nxt == 8'd0); fl_nxt[FL_N] = a_nxt[7];
            end
            OP_LDA_A, OP_LDA_AX: begin
              a_nxt = d; pc_nxt = pc_r + 16'd3;
              fl_nxt[FL_Z] = (d == 8'd0); fl_nxt[FL_N] = d[7];
            end
            OP_DEC_Z, OP_INC_Z: begin
              v = (opl_r == OP_DEC_Z) ? d - 8'd1 : d + 8'd1;
              fl_nxt[FL_Z] = (v == 8'd0); fl_nxt[FL_N] = v[7];
              rs[n] = mk_req({8'd0, lo_r}, 1'b1, v, 1'b0); n = n + 2'd1;
            end
            OP_RMB6: begin
              rs[n] = mk_req({8'd0, lo_r}, 1'b1, d & 8'hBF, 1'b0); n = n + 2'd1;
            end
            OP_SMB0: begin
              rs[n] = mk_req({8'd0, lo_r}, 1'b1, d | 8'h01, 1'b0); n = n + 2'd1;
            end
            OP_SMB2: begin
              rs[n] = mk_req({8'd0, lo_r}, 1'b1, d | 8'h04, 1'b0); n = n + 2'd1;
            end
            OP_SMB6: begin
              rs[n] = mk_req({8'd0, lo_r}, 1'b1, d | 8'h40, 1'b0); n = n + 2'd1;
            end
            OP_SMB7: begin
              rs[n] = mk_req({8'd0, lo_r}, 1'b1, d | 8'h80, 1'b0); n = n + 2'd1;
            end
            default: ;
          endcase
          rs[n] = mk_req(pc_nxt, 1'b0, 8'd0, 1'b0); n = n + 2'd1;
        end
        PH_IND1: begin
          rs[n] = mk_req({8'd0, lo_r + 8'd1}, 1'b0, 8'd0, 1'b0); n = n + 2'd1;
          lo_nxt = d;
          ph_nxt = PH_IND2;
        end
        PH_IND2: begin
          hi_nxt = d;
          rs[0] = mk_req({d, lo_r}, 1'b1, a_r, 1'b0);
          pc_nxt = pc_r + 16'd2;
          rs[1] = mk_req(pc_nxt, 1'b0, 8'd0, 1'b0);
          n = 2'd2;
          ph_nxt = PH_FETCH;
        end
        PH_POP1: begin
          if (opl_r == OP_RTS) begin
            hi_nxt = d;
            s_nxt = s_r - 8'd1;
            rs[n] = mk_req(base_r + {8'd0, s_nxt}, 1'b0, 8'd0, 1'b0); n = n + 2'd1;
            ph_nxt = PH_POP2;
          end else begin
            if (opl_r == OP_PLP) begin
              fl_nxt = {d[7], d[6], d[3:0]};
            end else begin
              a_nxt = d; fl_nxt[FL_Z] = (d == 8'd0); fl_nxt[FL_N] = d[7];
            end
            pc_nxt = pc_r + 16'd1;
            rs[n] = mk_req(pc_nxt, 1'b0, 8'd0, 1'b0); n = n + 2'd1;
            ph_nxt = PH_FETCH;
          end
        end
        PH_POP2: begin
          lo_nxt = d;
          pc_nxt = {hi_r, d} + 16'd1;
          rs[n] = mk_req(pc_nxt, 1'b0, 8'd0, 1'b0); n = n + 2'd1;
          ph_nxt = PH_FETCH;
        end
        default: ;
      endcase
    end
    if (n != 2'd0) rs[n - 2'd1].last = 1'b1;
  end

  // Architectural state and request buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= STACK_BASE_RST;
      a_r <= 8'd0; x_r <= 8'd0; y_r <= 8'd0; s_r <= 8'd0;
      pc_r <= 16'd0; fl_r <= 6'd0; ph_r <= PH_IDLE;
      opl_r <= 8'd0; lo_r <= 8'd0; hi_r <= 8'd0;
      cnt_r <= 2'd0; idx_r <= 2'd0;
    end else begin
      if (cfg_wr_en) base_r <= cfg_wr_data;
      if (load) begin
        a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt; s_r <= s_nxt;
        pc_r <= pc_nxt; fl_r <= fl_nxt; ph_r <= ph_nxt;
        opl_r <= opl_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
        cnt_r <= n; idx_r <= 2'd0;
      end else if (out_xfer) begin
        cnt_r <= cnt_r - 2'd1;
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  // Request payload buffer
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 3; i++) res_r[i] <= rs[i];
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cnt_r} + {1'b0, idx_r}) <= 3'd3)
    else $error("request buffer count out of range");
  a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cnt_r == 2'd1) |-> out_res.last)
    else $error("final request lacks last");
  a_last_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cnt_r > 2'd1) |-> !out_res.last)
    else $error("last set before final request");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > 2'd1) |-> !q_pop)
    else $error("item taken while requests pending");
`endif

endmodule

FILE: src/cpu_65c02_subset_core_top.sv
// Top level of the 65C02 subset core: input queue feeding the execute back end.
// Depends on cpu65_pkg, cpu65_front, cpu65_back.
//
//  channel | ports                                   | direction
//  input   | in_valid/in_stall, in_req_type, in_read_data | to core
//  result  | out_valid/out_stall, out_bus_addr .. out_last | from core
//  config  | cfg_wr_en, cfg_wr_data (stack_base)     | to core
//
// One bus request leaves per cycle while out_stall is low; an item causing k requests
// (0 to 3) occupies the back end until the request buffer has sent them all.
// A new item is executed in the cycle the last request of the previous one transfers.
// The two-entry input queue keeps taking items while requests stall, until it is full.
// Reset is synchronous, active low; the core then waits for a start item.
`timescale 1ns / 1ps
module cpu_65c02_subset_core_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_bus_addr,
  output logic        out_is_write,
  output logic [7:0]  out_write_data,
  output logic        out_fault,
  output logic        out_last
);
  import cpu65_pkg::*;

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;
  res_t  out_res;

  assign in_item.req_type  = in_req_type;
  assign in_item.read_data = in_read_data;

  cpu65_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  cpu65_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (out_res)
  );

  assign out_bus_addr   = out_res.bus_addr;
  assign out_is_write   = out_res.is_write;
  assign out_write_data = out_res.write_data;
  assign out_fault      = out_res.fault;
  assign out_last       = out_res.last;

endmodule
